// ===== rtl/cnv_pkg.sv =====
// Shared constants and types for the clamp-to-edge convolution block.
// Used by cnv_queue, cnv_front, cnv_back and the top level; no dependencies of its own.
`default_nettype none
package cnv_pkg;

    localparam int MAX_KERNEL_DEF = 7;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int QUEUE_DEPTH    = 4;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_KERNEL = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_NONE   = 2'd3;

    localparam logic [2:0]  KERNEL_RST = 3'd3;
    localparam logic [10:0] WIDTH_RST  = 11'd640;
    localparam logic [10:0] HEIGHT_RST = 11'd480;

    localparam int FRAC_BITS  = 12;
    localparam int ROUND_HALF = 2048;
    localparam int OUT_MAX    = 131071;
    localparam int OUT_MIN    = -131072;
    localparam int PROD_W     = 25;

    // Back-end status seen by the front end
    typedef struct packed {
        logic idle;      // no job in flight in the back end
        logic fe_done;   // frame-end result left the output register
    } back_stat_t;

endpackage
`default_nettype wire

// ===== rtl/cnv_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module cnv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/cnv_queue.sv =====
// Short job FIFO between front and back end.
// Depends on cnv_pkg for the depth constant.
`default_nettype none
module cnv_queue
    import cnv_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_reg, rd_reg;
    logic [PW:0]      cnt_reg;

    assign full     = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + PW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + (PW+1)'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - (PW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cnv_front.sv =====
// Front end: configuration registers, input classification, row store and
// coefficient writes, raster position tracking, job issue. Depends on cnv_pkg.
`default_nettype none
module cnv_front
    import cnv_pkg::*;
#(
    parameter int MAX_KERNEL = MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    localparam int TD  = MAX_KERNEL * MAX_KERNEL,
    localparam int CIW = (TD > 1) ? $clog2(TD) : 1,
    localparam int KW  = $clog2(MAX_KERNEL + 1),
    localparam int WW  = $clog2(MAX_WIDTH + 1),
    localparam int HW  = $clog2(MAX_HEIGHT + 1),
    localparam int CW  = $clog2(MAX_WIDTH),
    localparam int RW  = $clog2(MAX_HEIGHT),
    localparam int SD  = MAX_KERNEL * MAX_WIDTH,
    localparam int SAW = $clog2(SD),
    localparam int JW  = 1 + SAW + RW + CW
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [10:0]      cfg_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       operation,
    input  wire logic [5:0]       coeff_index,
    input  wire logic signed [15:0] coeff_value,
    input  wire logic [7:0]       pixel_value,
    output logic      [KW-1:0]    eff_k,
    output logic      [WW-1:0]    eff_w,
    output logic      [HW-1:0]    eff_h,
    output logic                  coef_we,
    output logic      [CIW-1:0]   coef_waddr,
    output logic      [15:0]      coef_wdata,
    output logic      [TD-1:0]    coef_valid,
    output logic                  pix_we,
    output logic      [SAW-1:0]   pix_waddr,
    output logic      [7:0]       pix_wdata,
    output logic                  q_push,
    output logic      [JW-1:0]    q_data,
    input  wire logic             q_full,
    input  wire logic             q_empty,
    input  wire back_stat_t       bstat
);

    localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    logic [2:0]       cfg_k_reg;
    logic [10:0]      cfg_w_reg, cfg_h_reg;
    logic [TD-1:0]    cvalid_reg;
    logic [POS_W-1:0] in_pos_reg, out_pos_reg;
    logic [SAW-1:0]   in_addr_reg, out_addr_reg;
    logic [CW-1:0]    out_col_reg;
    logic [RW-1:0]    out_row_reg;
    logic             frame_busy_reg;

    logic [KW-1:0]    k_min;
    logic [KW-1:0]    half;
    logic [POS_W-1:0] total, lag;
    logic             is_load, is_pix, is_drain, pix_take, pix_emit, drain_emit;
    logic             accept, emit, fe, load_ok;

    // Effective configuration: clamp and force odd kernel
    always_comb
    begin
        if (32'(cfg_k_reg) > 32'(MAX_KERNEL))
        begin
            k_min = KW'(MAX_KERNEL);
        end
        else
        begin
            k_min = KW'(cfg_k_reg);
        end
        if (k_min == '0)
        begin
            eff_k = KW'(1);
        end
        else if (!k_min[0])
        begin
            eff_k = k_min - KW'(1);
        end
        else
        begin
            eff_k = k_min;
        end
        if (cfg_w_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (32'(cfg_w_reg) > 32'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(cfg_w_reg);
        end
        if (cfg_h_reg == '0)
        begin
            eff_h = HW'(1);
        end
        else if (32'(cfg_h_reg) > 32'(MAX_HEIGHT))
        begin
            eff_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HW'(cfg_h_reg);
        end
    end

    assign half  = eff_k >> 1;
    assign total = POS_W'(eff_w) * POS_W'(eff_h);
    assign lag   = POS_W'(half) * POS_W'(eff_w) + POS_W'(half);

    assign is_load  = (operation == OP_LOAD);
    assign is_pix   = (operation == OP_PIXEL);
    assign is_drain = (operation == OP_DRAIN);

    assign pix_take   = (in_pos_reg < total);
    assign pix_emit   = pix_take && (in_pos_reg >= out_pos_reg + lag);
    assign drain_emit = (in_pos_reg >= total) && (out_pos_reg < total);
    assign load_ok    = bstat.idle && q_empty;

    always_comb
    begin
        case (operation)
            OP_LOAD:  in_ready = load_ok;
            OP_PIXEL: in_ready = !pix_take || (!frame_busy_reg && !(pix_emit && q_full));
            OP_DRAIN: in_ready = !(drain_emit && q_full);
            default:  in_ready = 1'b1;
        endcase
    end

    assign accept = in_valid && in_ready;
    assign emit   = accept && ((is_pix && pix_emit) || (is_drain && drain_emit));
    assign fe     = (out_pos_reg + POS_W'(1) == total);

    assign coef_we    = accept && is_load && (32'(coeff_index) < TD);
    assign coef_waddr = CIW'(coeff_index);
    assign coef_wdata = coeff_value;
    assign coef_valid = cvalid_reg;

    assign pix_we    = accept && is_pix && pix_take;
    assign pix_waddr = in_addr_reg;
    assign pix_wdata = pixel_value;

    assign q_push = emit;
    assign q_data = {fe, out_addr_reg, out_row_reg, out_col_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_k_reg      <= KERNEL_RST;
            cfg_w_reg      <= WIDTH_RST;
            cfg_h_reg      <= HEIGHT_RST;
            cvalid_reg     <= '0;
            in_pos_reg     <= '0;
            out_pos_reg    <= '0;
            in_addr_reg    <= '0;
            out_addr_reg   <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            frame_busy_reg <= 1'b0;
        end
        else
        begin
            if (bstat.fe_done)
            begin
                frame_busy_reg <= 1'b0;
            end
            if (coef_we)
            begin
                cvalid_reg[coef_waddr] <= 1'b1;
            end
            if (pix_we)
            begin
                in_pos_reg <= in_pos_reg + POS_W'(1);
                if (in_addr_reg == SAW'(SD - 1))
                begin
                    in_addr_reg <= '0;
                end
                else
                begin
                    in_addr_reg <= in_addr_reg + SAW'(1);
                end
            end
            if (emit)
            begin
                out_pos_reg <= out_pos_reg + POS_W'(1);
                if (out_addr_reg == SAW'(SD - 1))
                begin
                    out_addr_reg <= '0;
                end
                else
                begin
                    out_addr_reg <= out_addr_reg + SAW'(1);
                end
                if (32'(out_col_reg) + 1 == 32'(eff_w))
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + RW'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
                // last result of the frame: both sides restart
                if (fe)
                begin
                    in_pos_reg     <= '0;
                    in_addr_reg    <= '0;
                    out_pos_reg    <= '0;
                    out_addr_reg   <= '0;
                    out_col_reg    <= '0;
                    out_row_reg    <= '0;
                    frame_busy_reg <= 1'b1;
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_KERNEL: cfg_k_reg <= cfg_data[2:0];
                    CFG_WIDTH:  cfg_w_reg <= cfg_data;
                    CFG_HEIGHT: cfg_h_reg <= cfg_data;
                    default:    ;
                endcase
                if (cfg_index != CFG_NONE)
                begin
                    in_pos_reg   <= '0;
                    in_addr_reg  <= '0;
                    out_pos_reg  <= '0;
                    out_addr_reg <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cnv_back.sv =====
// Back end: per-job tap sequencer, clamped address generation, MAC pipeline,
// rounding, saturation and the output register. Depends on cnv_pkg.
`default_nettype none
module cnv_back
    import cnv_pkg::*;
#(
    parameter int MAX_KERNEL = MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    localparam int TD  = MAX_KERNEL * MAX_KERNEL,
    localparam int CIW = (TD > 1) ? $clog2(TD) : 1,
    localparam int KW  = $clog2(MAX_KERNEL + 1),
    localparam int WW  = $clog2(MAX_WIDTH + 1),
    localparam int HW  = $clog2(MAX_HEIGHT + 1),
    localparam int CW  = $clog2(MAX_WIDTH),
    localparam int RW  = $clog2(MAX_HEIGHT),
    localparam int SD  = MAX_KERNEL * MAX_WIDTH,
    localparam int SAW = $clog2(SD),
    localparam int JW  = 1 + SAW + RW + CW
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [KW-1:0]      eff_k,
    input  wire logic [WW-1:0]      eff_w,
    input  wire logic [HW-1:0]      eff_h,
    input  wire logic               q_empty,
    input  wire logic [JW-1:0]      q_data,
    output logic                    q_pop,
    output logic      [SAW-1:0]     pix_raddr,
    input  wire logic [7:0]         pix_rdata,
    output logic      [CIW-1:0]     coef_raddr,
    input  wire logic [15:0]        coef_rdata,
    input  wire logic [TD-1:0]      coef_valid,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [17:0]      filtered_value,
    output logic                    frame_end,
    output back_stat_t              bstat
);

    localparam int ACC_W = PROD_W + CIW;
    localparam int OFF_W = SAW + 2;
    localparam int RSW   = RW + 2;
    localparam int CSW   = CW + 2;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_PUT  = 2'd3;

    logic [1:0]               state_reg;
    logic [JW-1:0]            job_reg;
    logic [KW-1:0]            i_reg, j_reg;
    logic [CIW-1:0]           rbase_reg;
    logic                     v1_reg, v2_reg, cv1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg, out_fe_reg;
    logic signed [17:0]       out_value_reg;

    logic [CW-1:0]            j_col;
    logic [RW-1:0]            j_row;
    logic [SAW-1:0]           j_base;
    logic                     j_fe;
    logic [KW-1:0]            half;
    logic signed [RSW-1:0]    rr, dr;
    logic signed [CSW-1:0]    cc, dc;
    logic signed [OFF_W-1:0]  drw, sum;
    logic                     last_j, last_i, out_free;
    logic signed [ACC_W:0]    a_ext, mag, qv, rounded;
    logic signed [17:0]       sat;
    logic signed [15:0]       coef_eff;

    assign j_col  = job_reg[CW-1:0];
    assign j_row  = job_reg[CW+RW-1:CW];
    assign j_base = job_reg[CW+RW+SAW-1:CW+RW];
    assign j_fe   = job_reg[JW-1];
    assign half   = eff_k >> 1;

    // Tap address: clamp row and column, then offset from the centre pixel
    always_comb
    begin
        rr = $signed(RSW'(j_row)) - $signed(RSW'(half)) + $signed(RSW'(i_reg));
        if (rr < 0)
        begin
            rr = '0;
        end
        else if (rr > $signed(RSW'(eff_h)) - $signed(RSW'(1)))
        begin
            rr = $signed(RSW'(eff_h)) - $signed(RSW'(1));
        end
        dr = rr - $signed(RSW'(j_row));
        cc = $signed(CSW'(j_col)) - $signed(CSW'(half)) + $signed(CSW'(j_reg));
        if (cc < 0)
        begin
            cc = '0;
        end
        else if (cc > $signed(CSW'(eff_w)) - $signed(CSW'(1)))
        begin
            cc = $signed(CSW'(eff_w)) - $signed(CSW'(1));
        end
        dc  = cc - $signed(CSW'(j_col));
        drw = $signed(OFF_W'(dr)) * $signed(OFF_W'({1'b0, eff_w}));
        sum = $signed(OFF_W'(j_base)) + drw + OFF_W'(dc);
        if (sum < 0)
        begin
            sum = sum + $signed(OFF_W'(SD));
        end
        else if (sum >= $signed(OFF_W'(SD)))
        begin
            sum = sum - $signed(OFF_W'(SD));
        end
    end

    assign pix_raddr  = sum[SAW-1:0];
    assign coef_raddr = rbase_reg + CIW'(j_reg);
    assign last_j     = (j_reg == eff_k - KW'(1));
    assign last_i     = (i_reg == eff_k - KW'(1));
    assign q_pop      = (state_reg == S_IDLE) && !q_empty;
    assign out_free   = !out_valid_reg || out_ready;
    assign coef_eff   = cv1_reg ? $signed(coef_rdata) : 16'sd0;

    // Round half away from zero, then saturate
    always_comb
    begin
        a_ext = (ACC_W+1)'(acc_reg);
        mag   = (a_ext < 0) ? -a_ext : a_ext;
        qv    = (mag + (ACC_W+1)'(ROUND_HALF)) >>> FRAC_BITS;
        rounded = (a_ext < 0) ? -qv : qv;
        if (rounded > (ACC_W+1)'(OUT_MAX))
        begin
            sat = 18'(OUT_MAX);
        end
        else if (rounded < (ACC_W+1)'(OUT_MIN))
        begin
            sat = 18'(OUT_MIN);
        end
        else
        begin
            sat = rounded[17:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = out_value_reg;
    assign frame_end      = out_fe_reg;
    assign bstat          = '{idle:    (state_reg == S_IDLE),
                              fe_done: (out_valid_reg && out_ready && out_fe_reg)};

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
        end
        prod_reg <= $signed(PROD_W'($signed({1'b0, pix_rdata})))
                    * $signed(PROD_W'(coef_eff));
        if (state_reg == S_PUT && out_free)
        begin
            out_value_reg <= sat;
            out_fe_reg    <= j_fe;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            rbase_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            cv1_reg       <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg  <= (state_reg == S_RUN);
            cv1_reg <= coef_valid[coef_raddr];
            v2_reg  <= v1_reg;
            if (v2_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        rbase_reg <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (last_j)
                    begin
                        j_reg     <= '0;
                        i_reg     <= i_reg + KW'(1);
                        rbase_reg <= rbase_reg + CIW'(MAX_KERNEL);
                        if (last_i)
                        begin
                            state_reg <= S_WAIT;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + KW'(1);
                    end
                end
                S_WAIT:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        state_reg <= S_PUT;
                    end
                end
                S_PUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/image_convolution_clamped_edges.sv =====
// Top level of the clamp-to-edge KxK convolution block.
// Depends on cnv_pkg, cnv_front, cnv_queue, cnv_back and cnv_ram.
//
// Streams an 8-bit grayscale frame in raster order and returns the centred
// KxK convolution of each pixel with clamp-to-edge borders, rounded half
// away from zero and saturated to 18 bits signed. Each input transaction is
// a coefficient load (signed Q4.12, table index row*MAX_KERNEL+column), a
// pixel, or a drain that fetches one of the results still pending after the
// last pixel; results trail the input by half*W+half pixels. The front end
// takes one transaction per cycle while the job queue has room; each result
// is then computed by the back end: an issue step, one row-store and one
// coefficient read per tap through a single multiply-accumulate, a wait
// that flushes the read and multiply stages, and a load of the output
// register. The back end takes a new job only after the last one has
// reached the output register. A coefficient load waits until the back end
// has no job; the first pixel of a new frame waits until the previous
// frame's last result has been taken. A write to the kernel, width or height
// register restarts the frame; the coefficient table is kept and reads as
// zero until written. No clearing pass is needed after reset.
`default_nettype none
module image_convolution_clamped_edges
    import cnv_pkg::*;
#(
    parameter int MAX_KERNEL = MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [10:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic [5:0]         coeff_index,
    input  wire logic signed [15:0] coeff_value,
    input  wire logic [7:0]         pixel_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [17:0]      filtered_value,
    output logic                    frame_end
);

    localparam int TD  = MAX_KERNEL * MAX_KERNEL;
    localparam int CIW = (TD > 1) ? $clog2(TD) : 1;
    localparam int KW  = $clog2(MAX_KERNEL + 1);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SD  = MAX_KERNEL * MAX_WIDTH;
    localparam int SAW = $clog2(SD);
    localparam int JW  = 1 + SAW + RW + CW;

    logic [KW-1:0]  eff_k;
    logic [WW-1:0]  eff_w;
    logic [HW-1:0]  eff_h;
    logic           coef_we;
    logic [CIW-1:0] coef_waddr, coef_raddr;
    logic [15:0]    coef_wdata, coef_rdata;
    logic [TD-1:0]  coef_valid;
    logic           pix_we;
    logic [SAW-1:0] pix_waddr, pix_raddr;
    logic [7:0]     pix_wdata, pix_rdata;
    logic           q_push, q_pop, q_full, q_empty;
    logic [JW-1:0]  q_wdata, q_rdata;
    back_stat_t     bstat;

    // Front end: classifies transactions and issues one job per result
    cnv_front #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .coeff_index (coeff_index),
        .coeff_value (coeff_value),
        .pixel_value (pixel_value),
        .eff_k       (eff_k),
        .eff_w       (eff_w),
        .eff_h       (eff_h),
        .coef_we     (coef_we),
        .coef_waddr  (coef_waddr),
        .coef_wdata  (coef_wdata),
        .coef_valid  (coef_valid),
        .pix_we      (pix_we),
        .pix_waddr   (pix_waddr),
        .pix_wdata   (pix_wdata),
        .q_push      (q_push),
        .q_data      (q_wdata),
        .q_full      (q_full),
        .q_empty     (q_empty),
        .bstat       (bstat)
    );

    // Job queue decouples intake from the MAC sequencer
    cnv_queue #(
        .WIDTH (JW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Circular row store, addressed by raster position modulo its depth
    cnv_ram #(
        .WIDTH (8),
        .DEPTH (SD)
    ) u_row_store (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (pix_wdata),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    // Coefficient table; unwritten entries are masked by the valid bits
    cnv_ram #(
        .WIDTH (16),
        .DEPTH (TD)
    ) u_coef_table (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    // Back end: taps, MAC, rounding and the output register
    cnv_back #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .eff_k          (eff_k),
        .eff_w          (eff_w),
        .eff_h          (eff_h),
        .q_empty        (q_empty),
        .q_data         (q_rdata),
        .q_pop          (q_pop),
        .pix_raddr      (pix_raddr),
        .pix_rdata      (pix_rdata),
        .coef_raddr     (coef_raddr),
        .coef_rdata     (coef_rdata),
        .coef_valid     (coef_valid),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_value (filtered_value),
        .frame_end      (frame_end),
        .bstat          (bstat)
    );

endmodule
`default_nettype wire
